// ----- rtl/pcbnms_pkg.sv -----
// Shared types, constants and helper function of the per-class box NMS block.
package pcbnms_pkg;

   // one candidate box as held in a cell of the chain
   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic [15:0]        width;
      logic [15:0]        height;
      logic [15:0]        score;
      logic [7:0]         cls;
   } entry_type;

   // per-cycle command to every cell of the chain
   typedef struct packed {
      logic insert;   // sorted insert of the incoming candidate
      logic pop;      // shift toward the head, head leaves the chain
      logic append;   // write the returning entry behind the last valid cell
      logic clear;    // drop every entry
   } cell_ctrl_type;

   // depth of the overlap test pipeline
   localparam int unsigned IOU_LAT = 5;

   // clamp a Q.4 corner to [0, lim] and truncate to whole pixels
   function automatic logic [12:0] clamp_corner(logic signed [17:0] v, logic [12:0] lim);
      logic signed [18:0] v_ext;
      logic signed [18:0] lim_q4;
      logic [12:0]        res;
      v_ext  = {v[17], v};
      lim_q4 = {2'b00, lim, 4'b0000};
      if (v_ext <= 19'sd0) begin
         res = '0;
      end else if (v_ext >= lim_q4) begin
         res = lim;
      end else begin
         res = v_ext[16:4];
      end
      return res;
   endfunction

endpackage

// ----- rtl/pcbnms_cell.sv -----
// One cell of the candidate chain: holds one sorted entry and trades it with its neighbors.
module pcbnms_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  pcbnms_pkg::cell_ctrl_type ctrl,
   input  logic                      head,
   input  pcbnms_pkg::entry_type     new_entry,
   input  pcbnms_pkg::entry_type     fb_entry,
   input  pcbnms_pkg::entry_type     left_entry,
   input  logic                      left_valid,
   input  logic                      left_take,
   input  pcbnms_pkg::entry_type     right_entry,
   input  logic                      right_valid,
   output pcbnms_pkg::entry_type     own_entry,
   output logic                      own_valid,
   output logic                      own_take
);
   import pcbnms_pkg::*;

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;
   entry_type sh_entry;
   logic      sh_valid;
   logic      sh_left_valid;

   // new candidate goes ahead of this entry only on a strictly higher score
   assign own_take  = !valid_ff || (new_entry.score > entry_ff.score);
   assign own_entry = entry_ff;
   assign own_valid = valid_ff;

   // next contents
   always_comb begin
      sh_entry      = ctrl.pop ? right_entry : entry_ff;
      sh_valid      = ctrl.pop ? right_valid : valid_ff;
      sh_left_valid = head || (ctrl.pop ? valid_ff : left_valid);
      entry_in      = entry_ff;
      valid_in      = valid_ff;
      priority if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.insert) begin
         if (own_take) begin
            if (left_take) begin
               entry_in = left_entry;
               valid_in = left_valid;
            end else begin
               entry_in = new_entry;
               valid_in = 1'b1;
            end
         end
      end else begin
         entry_in = sh_entry;
         valid_in = sh_valid;
         if (ctrl.append && !sh_valid && sh_left_valid) begin
            entry_in = fb_entry;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

endmodule

// ----- rtl/pcbnms_iou.sv -----
// Pipelined overlap test of one candidate against the current pivot box.
module pcbnms_iou (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           thr,
   input  pcbnms_pkg::entry_type pivot,
   input  logic                  in_valid,
   input  pcbnms_pkg::entry_type in_entry,
   output logic                  out_valid,
   output logic                  out_keep,
   output pcbnms_pkg::entry_type out_entry,
   output logic                  busy
);
   import pcbnms_pkg::*;

   logic [IOU_LAT-1:0] vld_ff;
   entry_type          e1_ff, e2_ff, e3_ff, e4_ff, e5_ff;
   logic               m1_ff, m2_ff, m3_ff, m4_ff;
   logic               keep_ff;
   logic [16:0]        iw_ff, ih_ff, aw0_ff, ah0_ff, aw1_ff, ah1_ff;
   logic [33:0]        inter2_ff, a0_ff, a1_ff;
   logic [33:0]        inter3_ff, inter4_ff;
   logic [34:0]        uni_ff;
   logic [33:0]        plo_ff;
   logic [32:0]        phi_ff;

   logic signed [17:0] l0, t0, r0, b0, l1, t1, r1, b1;
   logic signed [18:0] iw_raw, ih_raw;
   logic [50:0]        rhs;
   logic [50:0]        lhs;

   // stage 1 edges and extents
   always_comb begin
      l0 = {{2{pivot.left[15]}}, pivot.left};
      t0 = {{2{pivot.top[15]}}, pivot.top};
      r0 = l0 + $signed({2'b00, pivot.width});
      b0 = t0 + $signed({2'b00, pivot.height});
      l1 = {{2{in_entry.left[15]}}, in_entry.left};
      t1 = {{2{in_entry.top[15]}}, in_entry.top};
      r1 = l1 + $signed({2'b00, in_entry.width});
      b1 = t1 + $signed({2'b00, in_entry.height});
      iw_raw = $signed({(r0 < r1) ? r0[17] : r1[17], (r0 < r1) ? r0 : r1})
             - $signed({(l0 > l1) ? l0[17] : l1[17], (l0 > l1) ? l0 : l1}) + 19'sd16;
      ih_raw = $signed({(b0 < b1) ? b0[17] : b1[17], (b0 < b1) ? b0 : b1})
             - $signed({(t0 > t1) ? t0[17] : t1[17], (t0 > t1) ? t0 : t1}) + 19'sd16;
      lhs = {1'b0, inter4_ff, 16'h0000};
      rhs = {phi_ff, 18'h00000} + {17'h00000, plo_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[IOU_LAT-2:0], in_valid};
      end
      // stage 1
      iw_ff  <= iw_raw[18] ? 17'd0 : iw_raw[16:0];
      ih_ff  <= ih_raw[18] ? 17'd0 : ih_raw[16:0];
      aw0_ff <= {1'b0, pivot.width} + 17'd16;
      ah0_ff <= {1'b0, pivot.height} + 17'd16;
      aw1_ff <= {1'b0, in_entry.width} + 17'd16;
      ah1_ff <= {1'b0, in_entry.height} + 17'd16;
      m1_ff  <= (pivot.cls == in_entry.cls);
      e1_ff  <= in_entry;
      // stage 2 products
      inter2_ff <= iw_ff * ih_ff;
      a0_ff     <= aw0_ff * ah0_ff;
      a1_ff     <= aw1_ff * ah1_ff;
      m2_ff     <= m1_ff;
      e2_ff     <= e1_ff;
      // stage 3 union
      uni_ff    <= {1'b0, a0_ff} + {1'b0, a1_ff} - {1'b0, inter2_ff};
      inter3_ff <= inter2_ff;
      m3_ff     <= m2_ff;
      e3_ff     <= e2_ff;
      // stage 4 threshold times union in two halves
      plo_ff    <= thr * uni_ff[17:0];
      phi_ff    <= thr * uni_ff[34:18];
      inter4_ff <= inter3_ff;
      m4_ff     <= m3_ff;
      e4_ff     <= e3_ff;
      // stage 5 compare
      keep_ff <= !(m4_ff && (lhs > rhs));
      e5_ff   <= e4_ff;
   end

   assign out_valid = vld_ff[IOU_LAT-1];
   assign out_keep  = keep_ff;
   assign out_entry = e5_ff;
   assign busy      = |vld_ff;

endmodule

// ----- rtl/per_class_box_nms.sv -----
// Top level of the per-class box NMS block: chain of sorted cells, overlap unit, control.
//
//  channel | role      | payload
//  req_*   | candidate | tdata: left, top, width, height, score, class; tlast: last of frame
//  rsp_*   | kept box  | tdata: left, top, right, bottom, score, class; tuser: none kept
//  csr_*   | registers | iou_threshold @0x0, image_width @0x4, image_height @0x8
//
// Loading takes one candidate per cycle; the chain keeps them sorted by score on the fly.
// After the last candidate, a start step begins the frame. Each surviving pivot then leaves the
// head, the boxes behind it circulate once through the 5-stage overlap unit, and a hand-over
// step passes on the result; a pivot with nothing behind it sends nothing through the unit.
// Reset clears all control and cell valid bits at once; no clearing pass is needed.
// A stalled result channel holds the block in its hand-over step; input waits until done.
module per_class_box_nms #(
   parameter int unsigned CAND_DEPTH = 1024,
   parameter int unsigned MAX_OUT    = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // left, top, width, height, score, class_id
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // left, top, right, bottom, score, class, zero pad
   output logic        rsp_tuser,   // none_kept
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pcbnms_pkg::*;

   localparam int unsigned CW = $clog2(CAND_DEPTH + 1);
   localparam int unsigned EW = $clog2(MAX_OUT + 1);

   localparam logic [1:0] REG_THR = 2'd0;
   localparam logic [1:0] REG_IMW = 2'd1;
   localparam logic [1:0] REG_IMH = 2'd2;

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_PIVOT = 3'd2;
   localparam logic [2:0] ST_PASS  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [15:0]   thr_ff;
   logic [12:0]   imw_ff, imh_ff;
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] left_ff, left_in;
   logic [EW-1:0] emitted_ff, emitted_in;
   logic          none_ff, none_in;
   entry_type     pivot_ff, pivot_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [79:0]   rsp_data_ff, rsp_data_in;
   logic          rsp_user_ff, rsp_user_in;
   logic          rsp_last_ff, rsp_last_in;

   cell_ctrl_type           ctrl;
   entry_type               new_entry;
   entry_type               cell_entry [CAND_DEPTH];
   logic [CAND_DEPTH-1:0]   cell_valid;
   logic [CAND_DEPTH-1:0]   cell_take;

   logic      req_fire, cfg_write, issue, emit_fire, emit_last;
   logic      iou_valid, iou_keep, iou_busy;
   entry_type iou_entry;
   logic signed [17:0] right_q4, bottom_q4;

   // unpack the incoming candidate
   assign new_entry.left   = req_tdata[15:0];
   assign new_entry.top    = req_tdata[31:16];
   assign new_entry.width  = req_tdata[47:32];
   assign new_entry.height = req_tdata[63:48];
   assign new_entry.score  = req_tdata[79:64];
   assign new_entry.cls    = req_tdata[87:80];

   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid && req_tready;

   // register port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_THR: csr_prdata = {16'h0000, thr_ff};
         REG_IMW: csr_prdata = {19'h00000, imw_ff};
         REG_IMH: csr_prdata = {19'h00000, imh_ff};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 16'd29491;
         imw_ff <= 13'd640;
         imh_ff <= 13'd640;
      end else if (cfg_write) begin
         if (csr_paddr[3:2] == REG_THR) begin
            thr_ff <= csr_pwdata[15:0];
         end
         if (csr_paddr[3:2] == REG_IMW) begin
            imw_ff <= csr_pwdata[12:0];
         end
         if (csr_paddr[3:2] == REG_IMH) begin
            imh_ff <= csr_pwdata[12:0];
         end
      end
   end

   // chain of candidate cells, head at index 0
   for (genvar k = 0; k < CAND_DEPTH; k++) begin : g_cell
      entry_type l_entry, r_entry;
      logic      l_valid, l_take, r_valid;
      if (k == 0) begin : g_head
         assign l_entry = new_entry;
         assign l_valid = 1'b1;
         assign l_take  = 1'b0;
      end else begin : g_body
         assign l_entry = cell_entry[k-1];
         assign l_valid = cell_valid[k-1];
         assign l_take  = cell_take[k-1];
      end
      if (k == CAND_DEPTH - 1) begin : g_tail
         assign r_entry = '0;
         assign r_valid = 1'b0;
      end else begin : g_inner
         assign r_entry = cell_entry[k+1];
         assign r_valid = cell_valid[k+1];
      end
      pcbnms_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .head        (k == 0),
         .new_entry   (new_entry),
         .fb_entry    (iou_entry),
         .left_entry  (l_entry),
         .left_valid  (l_valid),
         .left_take   (l_take),
         .right_entry (r_entry),
         .right_valid (r_valid),
         .own_entry   (cell_entry[k]),
         .own_valid   (cell_valid[k]),
         .own_take    (cell_take[k])
      );
   end

   // overlap unit, fed from the head of the chain
   pcbnms_iou u_iou (
      .clock     (clock),
      .reset     (reset),
      .thr       (thr_ff),
      .pivot     (pivot_ff),
      .in_valid  (issue),
      .in_entry  (cell_entry[0]),
      .out_valid (iou_valid),
      .out_keep  (iou_keep),
      .out_entry (iou_entry),
      .busy      (iou_busy)
   );

   assign right_q4  = {{2{pivot_ff.left[15]}}, pivot_ff.left} + $signed({2'b00, pivot_ff.width});
   assign bottom_q4 = {{2{pivot_ff.top[15]}}, pivot_ff.top} + $signed({2'b00, pivot_ff.height});

   assign issue     = (state_ff == ST_PASS) && (left_ff != '0);
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign emit_last = none_ff || (cnt_ff == '0) || (emitted_ff == EW'(MAX_OUT - 1));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      left_in      = left_ff;
      emitted_in   = emitted_ff;
      none_in      = none_ff;
      pivot_in     = pivot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      ctrl         = '0;
      ctrl.append  = iou_valid && iou_keep;
      if (ctrl.append) begin
         cnt_in = cnt_in + CW'(1);
      end
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               ctrl.insert = 1'b1;
               if (cnt_ff != CW'(CAND_DEPTH)) begin
                  cnt_in = cnt_ff + CW'(1);
               end
               if (req_tlast) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            emitted_in = '0;
            none_in    = (cnt_ff == '0);
            state_in   = (cnt_ff == '0) ? ST_EMIT : ST_PIVOT;
         end
         ST_PIVOT: begin
            ctrl.pop = 1'b1;
            pivot_in = cell_entry[0];
            cnt_in   = cnt_ff - CW'(1);
            left_in  = cnt_ff - CW'(1);
            state_in = ST_PASS;
         end
         ST_PASS: begin
            if (issue) begin
               ctrl.pop = 1'b1;
               cnt_in   = cnt_in - CW'(1);
               left_in  = left_ff - CW'(1);
            end else if (!iou_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = none_ff;
               rsp_last_in  = emit_last;
               if (none_ff) begin
                  rsp_data_in = '0;
               end else begin
                  rsp_data_in = {4'h0, pivot_ff.cls, pivot_ff.score,
                                 clamp_corner(bottom_q4, imh_ff),
                                 clamp_corner(right_q4, imw_ff),
                                 clamp_corner({{2{pivot_ff.top[15]}}, pivot_ff.top}, imh_ff),
                                 clamp_corner({{2{pivot_ff.left[15]}}, pivot_ff.left}, imw_ff)};
               end
               emitted_in = emitted_ff + EW'(1);
               if (emit_last) begin
                  ctrl.clear = 1'b1;
                  cnt_in     = '0;
                  none_in    = 1'b0;
                  state_in   = ST_LOAD;
               end else begin
                  state_in = ST_PIVOT;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         left_ff      <= '0;
         emitted_ff   <= '0;
         none_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         left_ff      <= left_in;
         emitted_ff   <= emitted_in;
         none_ff      <= none_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pivot_ff    <= pivot_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // occupied cells form an unbroken run from the head and match the count
   a_chain_packed : assert property (@(posedge clock) disable iff (reset)
      ((cell_valid & (cell_valid + 1'b1)) == '0) && ($countones(cell_valid) == cnt_ff))
      else $error("chain occupancy broken");

   // an empty-frame result always closes the frame
   a_none_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff) |-> rsp_last_ff)
      else $error("none_kept without last");

   // closing the frame empties the chain
   a_clear : assert property (@(posedge clock) disable iff (reset)
      (emit_fire && emit_last) |=> (cell_valid == '0))
      else $error("chain not cleared at end of frame");

   // the overlap unit only runs during a suppression pass
   a_iou_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> !iou_busy)
      else $error("overlap unit busy while loading");

endmodule

// ----- bench/per_class_box_nms_tb.sv -----
// Self-checking testbench of the per-class box NMS block: table, random frames, predictor.
module per_class_box_nms_tb;
   import pcbnms_pkg::*;

   localparam int unsigned DEPTH     = 1024;
   localparam int unsigned OUT_LIMIT = 64;
   localparam int unsigned WD_LIMIT  = 200000;
   localparam int unsigned BURST     = 16;

   localparam logic [3:0] ADDR_IOU_THR = 4'h0;
   localparam logic [3:0] ADDR_IMG_W   = 4'h4;
   localparam logic [3:0] ADDR_IMG_H   = 4'h8;

   typedef struct {
      logic [12:0] l;
      logic [12:0] t;
      logic [12:0] r;
      logic [12:0] b;
      logic [15:0] score;
      logic [7:0]  cls;
      logic        none;
      logic        last;
   } kept_box_type;

   typedef struct {
      entry_type    cand;
      logic         last;
      logic         typed;
      kept_box_type want;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;   // left, top, width, height, score, class_id
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // left, top, right, bottom, score, class, zero pad
   logic        rsp_tuser;        // none_kept
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   per_class_box_nms u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state: sorted candidates and register copies
   entry_type   sorted_cands[$];
   logic [15:0] thr_q16 = 16'd29491;
   logic [12:0] img_w   = 13'd640;
   logic [12:0] img_h   = 13'd640;

   kept_box_type  pending_boxes[$];
   table_row_type rows[$];
   int            mismatches = 0;
   bit            calm = 0;
   int unsigned   quiet_cycles = 0;

   // append an expected box behind the ones already waiting
   function automatic void queue_box(kept_box_type k);
      pending_boxes.insert(pending_boxes.size(), k);
   endfunction

   function automatic void add_row(table_row_type r);
      rows.insert(rows.size(), r);
   endfunction

   function automatic logic [12:0] clamp_px(longint v, logic [12:0] lim);
      if (v <= 0) return '0;
      if (v >= longint'(lim) * 16) return lim;
      return 13'(v >>> 4);
   endfunction

   function automatic bit iou_exceeds(entry_type a, entry_type b);
      longint l0, t0, r0, b0, l1, t1, r1, b1, iw, ih, inter, uni;
      l0 = a.left; t0 = a.top;
      r0 = l0 + longint'(a.width); b0 = t0 + longint'(a.height);
      l1 = b.left; t1 = b.top;
      r1 = l1 + longint'(b.width); b1 = t1 + longint'(b.height);
      iw = ((r0 < r1) ? r0 : r1) - ((l0 > l1) ? l0 : l1) + 16;
      ih = ((b0 < b1) ? b0 : b1) - ((t0 > t1) ? t0 : t1) + 16;
      if (iw < 0) iw = 0;
      if (ih < 0) ih = 0;
      inter = iw * ih;
      uni = (r0 - l0 + 16) * (b0 - t0 + 16) + (r1 - l1 + 16) * (b1 - t1 + 16) - inter;
      if (uni <= 0) return 0;
      return inter * 65536 > longint'(thr_q16) * uni;
   endfunction

   // sorted insert; ties stay behind earlier arrivals, a full store drops its lowest
   function automatic void load_candidate(entry_type c);
      int pos;
      pos = 0;
      while (pos < sorted_cands.size() && sorted_cands[pos].score >= c.score) pos++;
      if (pos >= DEPTH) return;
      if (sorted_cands.size() == DEPTH) void'(sorted_cands.pop_back());
      sorted_cands.insert(pos, c);
   endfunction

   // greedy same-class suppression, then queue the survivors as expected boxes
   function automatic void suppress_and_emit();
      bit           dropped[];
      int           n, kept;
      kept_box_type k;
      n = sorted_cands.size();
      dropped = new[n];
      kept = 0;
      for (int i = 0; i < n; i++) begin
         if (dropped[i]) continue;
         for (int j = i + 1; j < n; j++) begin
            if (dropped[j] || sorted_cands[j].cls != sorted_cands[i].cls) continue;
            if (iou_exceeds(sorted_cands[i], sorted_cands[j])) dropped[j] = 1;
         end
      end
      for (int i = 0; i < n && kept < OUT_LIMIT; i++) begin
         if (dropped[i]) continue;
         k.l     = clamp_px(sorted_cands[i].left, img_w);
         k.t     = clamp_px(sorted_cands[i].top, img_h);
         k.r     = clamp_px(longint'(sorted_cands[i].left) + sorted_cands[i].width, img_w);
         k.b     = clamp_px(longint'(sorted_cands[i].top) + sorted_cands[i].height, img_h);
         k.score = sorted_cands[i].score;
         k.cls   = sorted_cands[i].cls;
         k.none  = 1'b0;
         k.last  = 1'b0;
         queue_box(k);
         kept++;
      end
      if (kept == 0) begin
         k = '{default: '0};
         k.none = 1'b1;
         queue_box(k);
      end
      pending_boxes[pending_boxes.size() - 1].last = 1'b1;
      sorted_cands.delete();
   endfunction

   // drive one candidate, idling at random first; returns once the transfer happens
   task automatic send_cand(entry_type c, logic last);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {c.cls, c.score, c.height, c.width, c.top, c.left};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      load_candidate(c);
      if (last) suppress_and_emit();
   endtask

   task automatic csr_write(logic [3:0] addr, logic [31:0] data);
      @(negedge clock);
      req_tvalid  <= 1'b0;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // hold off until every expected box has come, then let the block settle
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_boxes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_config(logic [15:0] thr, logic [12:0] w, logic [12:0] h);
      drain();
      csr_write(ADDR_IOU_THR, 32'(thr));
      csr_write(ADDR_IMG_W, 32'(w));
      csr_write(ADDR_IMG_H, 32'(h));
      thr_q16 = thr;
      img_w   = w;
      img_h   = h;
   endtask

   // random frame: mostly clustered boxes of few classes, some raw noise
   task automatic send_frame(int n);
      entry_type c;
      int        cx, cy;
      cx = $urandom_range(0, 12000) - 2000;
      cy = $urandom_range(0, 12000) - 2000;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) begin
            c = entry_type'(88'({$urandom, $urandom, $urandom}));
         end else begin
            if ($urandom_range(3) == 0) begin
               cx = $urandom_range(0, 12000) - 2000;
               cy = $urandom_range(0, 12000) - 2000;
            end
            c.left   = 16'(cx + $urandom_range(0, 96) - 48);
            c.top    = 16'(cy + $urandom_range(0, 96) - 48);
            c.width  = 16'($urandom_range(16, 1600));
            c.height = 16'($urandom_range(16, 1600));
            c.score  = ($urandom_range(3) == 0) ? 16'($urandom_range(4) * 16000)
                                                : 16'($urandom);
            c.cls    = 8'($urandom_range(0, 3));
         end
         send_cand(c, i == n - 1);
      end
   endtask

   task automatic chk(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %0d actual %0d", name, want, got);
      end
   endtask

   // result check against the oldest expected box
   always @(posedge clock) begin
      kept_box_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_boxes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: unexpected result %h", rsp_tdata);
         end else begin
            w = pending_boxes.pop_front();
            chk("left", 16'(w.l), 16'(rsp_tdata[12:0]));
            chk("top", 16'(w.t), 16'(rsp_tdata[25:13]));
            chk("right", 16'(w.r), 16'(rsp_tdata[38:26]));
            chk("bottom", 16'(w.b), 16'(rsp_tdata[51:39]));
            chk("score", w.score, rsp_tdata[67:52]);
            chk("class", 16'(w.cls), 16'(rsp_tdata[75:68]));
            chk("none_kept", 16'(w.none), 16'(rsp_tuser));
            chk("last", 16'(w.last), 16'(rsp_tlast));
         end
      end
   end

   // result-side stall
   always @(negedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WD_LIMIT) begin
            $display("FAIL per_class_box_nms");
            $finish;
         end
      end
   end

   function automatic entry_type mk(int l, int t, int w, int h, int s, int c);
      entry_type e;
      e.left = 16'(l); e.top = 16'(t); e.width = 16'(w); e.height = 16'(h);
      e.score = 16'(s); e.cls = 8'(c);
      return e;
   endfunction

   function automatic kept_box_type kb(int l, int t, int r, int b, int s, int c);
      kept_box_type k;
      k.l = 13'(l); k.t = 13'(t); k.r = 13'(r); k.b = 13'(b);
      k.score = 16'(s); k.cls = 8'(c); k.none = 1'b0; k.last = 1'b1;
      return k;
   endfunction

   initial begin
      kept_box_type no_box;
      entry_type    c;
      no_box = '{default: '0};

      // single-box frames read off at a glance, then overlap, tie and class cases
      add_row('{mk(160, 320, 160, 80, 1000, 3), 1, 1, kb(10, 20, 20, 25, 1000, 3)});
      add_row('{mk(-32768, -32768, 65535, 65535, 65535, 255), 1, 1,
                kb(0, 0, 640, 640, 65535, 255)});
      add_row('{mk(32767, 32767, 0, 0, 0, 0), 1, 1, kb(640, 640, 640, 640, 0, 0)});
      add_row('{mk(-16, 15, 17, 1, 1, 128), 1, 1, kb(0, 0, 0, 1, 1, 128)});
      add_row('{mk(0, 0, 800, 800, 500, 1), 0, 0, no_box});
      add_row('{mk(16, 16, 800, 800, 900, 1), 0, 0, no_box});
      add_row('{mk(32, 0, 800, 800, 500, 2), 0, 0, no_box});
      add_row('{mk(4000, 4000, 160, 160, 500, 1), 0, 0, no_box});
      add_row('{mk(4000, 4000, 160, 160, 500, 1), 0, 0, no_box});
      add_row('{mk(4010, 4000, 160, 160, 700, 1), 1, 0, no_box});
      add_row('{mk(100, 100, 100, 100, 300, 7), 0, 0, no_box});
      add_row('{mk(100, 100, 100, 100, 300, 8), 0, 0, no_box});
      add_row('{mk(120, 100, 100, 100, 300, 7), 0, 0, no_box});
      add_row('{mk(9000, 9000, 30000, 30000, 65535, 7), 1, 0, no_box});

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         send_cand(rows[i].cand, rows[i].last);
         if (rows[i].typed) begin
            void'(pending_boxes.pop_back());
            queue_box(rows[i].want);
         end
      end

      // a burst of identical boxes of one class with random scores
      for (int i = 0; i < BURST; i++) begin
         c = mk(800, 800, 320, 320, $urandom_range(0, 4000), 9);
         send_cand(c, i == BURST - 1);
      end

      set_config(16'd0, 13'd1, 13'd1);
      repeat (4) send_frame($urandom_range(1, 8));
      set_config(16'd65535, 13'd4096, 13'd4096);
      send_frame(25);
      repeat (3) send_frame($urandom_range(1, 8));
      set_config(16'd0, 13'd0, 13'd8191);
      repeat (3) send_frame($urandom_range(1, 6));
      calm = 1;
      set_config(16'($urandom), 13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
      repeat (5) send_frame($urandom_range(1, 10));
      calm = 0;
      set_config(16'd29491, 13'd640, 13'd640);
      repeat (5) send_frame($urandom_range(1, 10));
      set_config(16'($urandom), 13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
      repeat (4) send_frame($urandom_range(1, 8));

      drain();
      if (mismatches == 0 && pending_boxes.size() == 0) begin
         $display("PASS per_class_box_nms");
      end else begin
         $display("FAIL per_class_box_nms");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/pcbnms_pkg.sv
rtl/pcbnms_cell.sv
rtl/pcbnms_iou.sv
rtl/per_class_box_nms.sv
bench/per_class_box_nms_tb.sv
